// ===== design/utf8_word_tokenizer_assert.svh =====
// Assertion macros for the UTF-8 word tokenizer checker.
// Included by design/uwt_checker.sv; no other dependencies.
`ifndef UTF8_WORD_TOKENIZER_ASSERT_SVH
`define UTF8_WORD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UWT_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UWT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define UWT_ASSERT_ALWAYS_NEXT(label, clk, pre, post, msg) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/uwt_pkg.sv =====
// Shared types and constants for the UTF-8 word tokenizer.
// No dependencies; used by utf8_word_tokenizer and uwt_checker.
`default_nettype none

package uwt_pkg;

    localparam int OFFSET_W = 16;
    localparam int COUNT_W  = 17;

    localparam logic [COUNT_W-1:0]  MAX_TEXT_BYTES = 17'h10000;
    localparam logic [OFFSET_W-1:0] MAX_OFFSET     = 16'hFFFF;

    localparam logic [31:0] CP_NEL          = 32'd133;
    localparam logic [31:0] CP_IDEO_SPACE   = 32'h3000;
    localparam logic [31:0] CP_BOM          = 32'hFEFF;
    localparam logic [31:0] CP_PUNCT_LO     = 32'h2000;
    localparam logic [31:0] CP_PUNCT_HI     = 32'h206F;
    localparam logic [31:0] CP_SPACE_HI     = 32'h200F;
    localparam logic [31:0] CP_LINE_SEP     = 32'h2028;
    localparam logic [31:0] CP_PARA_SEP     = 32'h2029;
    localparam logic [31:0] CP_NARROW_NBSP  = 32'h202F;
    localparam logic [31:0] CP_MATH_SPACE   = 32'h205F;
    localparam logic [31:0] CP_WORD_JOINER  = 32'h2060;

    localparam logic SPLIT_WORD       = 1'b0;
    localparam logic SPLIT_WHITESPACE = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic                token_valid;
        logic [OFFSET_W-1:0] token_start;
        logic [COUNT_W-1:0]  token_length;
        logic                text_done;
    } out_t;

endpackage

`default_nettype wire

// ===== design/utf8_word_tokenizer.sv =====
// UTF-8 tokenizer top level: input register, decode/classify, result register.
// Depends on uwt_pkg (types and constants).
//
// Usage:
//   s_valid/s_ready/s_data carry one text byte per transfer plus an
//   end_of_text flag on the final byte. m_valid/m_ready/m_data carry one
//   result: a token (start offset, byte length) when a delimiter closes it,
//   and always one result on the final byte with text_done set.
//   cfg_wr_en/cfg_wr_data write split_mode (0 word, 1 whitespace) while idle.
//   A byte's result goes from the input register through the classify stage
//   into the result register, from which it shows on m_data.
//   Throughput: one byte per cycle unless stalled as below; the only loop is
//   the update of the decoder and token state in the classify stage.
//   A stalled receiver holds the result register; the classify stage keeps
//   going for bytes that make no result and stops, with s_ready low, only
//   when a byte has a result to deliver and the result register is full.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   text state and sets split_mode to word mode.
`default_nettype none

module utf8_word_tokenizer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire uwt_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output uwt_pkg::out_t     m_data,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data
);

    function automatic logic ascii_delim(input logic [7:0] b, input logic mode);
        logic d;
        if (b <= 8'd32) begin
            d = 1'b1;
        end else if (mode == uwt_pkg::SPLIT_WHITESPACE) begin
            d = 1'b0;
        end else if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            d = 1'b0;
        end else begin
            d = 1'b1;
        end
        return d;
    endfunction

    function automatic logic code_delim(input logic [31:0] c, input logic mode);
        logic d;
        if (c == uwt_pkg::CP_NEL || c == uwt_pkg::CP_IDEO_SPACE || c == uwt_pkg::CP_BOM) begin
            d = 1'b1;
        end else if (mode == uwt_pkg::SPLIT_WORD) begin
            d = c inside {[uwt_pkg::CP_PUNCT_LO:uwt_pkg::CP_PUNCT_HI]};
        end else begin
            d = c inside {[uwt_pkg::CP_PUNCT_LO:uwt_pkg::CP_SPACE_HI],
                          [uwt_pkg::CP_LINE_SEP:uwt_pkg::CP_PARA_SEP],
                          uwt_pkg::CP_NARROW_NBSP,
                          [uwt_pkg::CP_MATH_SPACE:uwt_pkg::CP_WORD_JOINER]};
        end
        return d;
    endfunction

    logic                         mode_reg;
    logic                         in_vld_reg;
    uwt_pkg::in_t                 in_data_reg;
    logic                         m_valid_reg;
    uwt_pkg::out_t                m_data_reg;

    logic [uwt_pkg::COUNT_W-1:0]  pos_reg, pos_next;
    logic [uwt_pkg::OFFSET_W-1:0] cb_reg, cb_next;
    logic [31:0]                  acc_reg, acc_next;
    logic [2:0]                   pend_reg, pend_next;
    logic                         tok_reg, tok_next;
    logic [uwt_pkg::OFFSET_W-1:0] open_reg, open_next;

    logic [7:0]                   b;
    logic                         eot;
    logic                         complete;
    logic                         delim;
    logic                         emit_delim;
    logic                         produce;
    logic                         adv;
    logic [uwt_pkg::COUNT_W-1:0]  pos_inc;
    uwt_pkg::out_t                res;

    always_comb begin
        b         = in_data_reg.text_byte;
        eot       = in_data_reg.end_of_text;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        cb_next   = cb_reg;
        complete  = 1'b0;
        delim     = 1'b0;

        if (pend_reg != 3'd0) begin
            acc_next  = {acc_reg[25:0], b[5:0]};
            pend_next = pend_reg - 3'd1;
            if (pend_next == 3'd0 || eot) begin
                complete = 1'b1;
                delim    = code_delim(acc_next, mode_reg);
            end
        end else begin
            cb_next = pos_reg[uwt_pkg::COUNT_W-1] ? uwt_pkg::MAX_OFFSET
                                                  : pos_reg[uwt_pkg::OFFSET_W-1:0];
            if (b < 8'h80) begin
                complete = 1'b1;
                delim    = ascii_delim(b, mode_reg);
            end else if (b inside {[8'h80:8'hBF], [8'hFE:8'hFF]}) begin
                // stray continuation or invalid lead: one-byte word character
                complete = 1'b1;
            end else begin
                if (b < 8'hE0) begin
                    acc_next  = {27'd0, b[4:0]};
                    pend_next = 3'd1;
                end else if (b < 8'hF0) begin
                    acc_next  = {28'd0, b[3:0]};
                    pend_next = 3'd2;
                end else if (b < 8'hF8) begin
                    acc_next  = {29'd0, b[2:0]};
                    pend_next = 3'd3;
                end else if (b < 8'hFC) begin
                    acc_next  = {30'd0, b[1:0]};
                    pend_next = 3'd4;
                end else begin
                    acc_next  = {31'd0, b[0]};
                    pend_next = 3'd5;
                end
                if (eot) begin
                    complete = 1'b1;
                    delim    = code_delim(acc_next, mode_reg);
                end
            end
        end

        pos_inc = pos_reg[uwt_pkg::COUNT_W-1] ? pos_reg : pos_reg + 17'd1;

        emit_delim = complete && delim && tok_reg;
        tok_next   = tok_reg;
        open_next  = open_reg;
        if (complete) begin
            if (delim) begin
                tok_next = 1'b0;
            end else if (!tok_reg) begin
                tok_next  = 1'b1;
                open_next = cb_next;
            end
        end

        produce = emit_delim || eot;

        if (emit_delim) begin
            res.token_valid  = 1'b1;
            res.token_start  = open_reg;
            res.token_length = {1'b0, cb_next} - {1'b0, open_reg};
            res.text_done    = eot;
        end else if (tok_next) begin
            res.token_valid  = 1'b1;
            res.token_start  = open_next;
            res.token_length = pos_inc - {1'b0, open_next};
            res.text_done    = 1'b1;
        end else begin
            res.token_valid  = 1'b0;
            res.token_start  = '0;
            res.token_length = '0;
            res.text_done    = 1'b1;
        end

        pos_next = pos_inc;
        if (eot) begin
            pos_next  = '0;
            cb_next   = '0;
            acc_next  = '0;
            pend_next = '0;
            tok_next  = 1'b0;
            open_next = '0;
        end
    end

    assign adv     = in_vld_reg && (!produce || !m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= uwt_pkg::SPLIT_WORD;
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            cb_reg      <= '0;
            acc_reg     <= '0;
            pend_reg    <= '0;
            tok_reg     <= 1'b0;
            open_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (adv) begin
                pos_reg  <= pos_next;
                cb_reg   <= cb_next;
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                tok_reg  <= tok_next;
                open_reg <= open_next;
            end
            if (adv && produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv && produce) begin
            m_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== design/uwt_checker.sv =====
// Port-level checker for the UTF-8 word tokenizer, bound to the top level.
// Depends on uwt_pkg and utf8_word_tokenizer_assert.svh.
`default_nettype none

`include "utf8_word_tokenizer_assert.svh"

module uwt_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire uwt_pkg::out_t m_data
);

    logic [uwt_pkg::COUNT_W:0] tok_end;

    assign tok_end = {2'b00, m_data.token_start} + {1'b0, m_data.token_length};

    `UWT_ASSERT_ALWAYS_NEXT(a_reset_empties, aclk, !aresetn, !m_valid, "result after reset")

    `UWT_ASSERT_ALWAYS_NEXT(a_ready_after_reset, aclk, !aresetn, s_ready, "not ready after reset")

    `UWT_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled transfer changed")

    `UWT_ASSERT_NOW(a_empty_result, aclk, aresetn, m_valid && !m_data.token_valid, m_data.text_done && m_data.token_start == '0 && m_data.token_length == '0, "bad end-of-text result")

    `UWT_ASSERT_NOW(a_token_in_text, aclk, aresetn, m_valid && m_data.token_valid, tok_end <= {1'b0, uwt_pkg::MAX_TEXT_BYTES}, "token runs past text limit")

endmodule

bind utf8_word_tokenizer uwt_checker u_uwt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

`default_nettype wire

// ===== verif/utf8_word_tokenizer_tb.sv =====
// Self-checking testbench for utf8_word_tokenizer: streams UTF-8 texts in both split modes
// under random source gaps and sink stalls, and checks every token against an internal model.
// Depends on design/uwt_pkg.sv and design/utf8_word_tokenizer.sv.
`timescale 1ns / 1ps

module utf8_word_tokenizer_tb;

    localparam int RUN_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1760;
    localparam int MODE_PHASE_ITEMS = 300;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    uwt_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    uwt_pkg::out_t m_data;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_wr_data = 1'b0;

    utf8_word_tokenizer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // tokenizer model state
    logic        mode_reg = uwt_pkg::SPLIT_WORD;
    logic [16:0] text_pos = '0;
    logic [15:0] char_offset = '0;
    logic [31:0] code_acc = '0;
    logic [2:0]  cont_left = '0;
    logic        token_open = 1'b0;
    logic [15:0] token_origin = '0;

    uwt_pkg::out_t token_queue[$];
    logic [7:0]    text_buf[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            items_sent = 0;
    bit            fast_source = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void buf_add(input logic [7:0] v);
        text_buf.insert(text_buf.size(), v);
    endfunction

    function automatic logic ascii_is_delim(input logic [7:0] b);
        if (b <= 8'd32) return 1'b1;
        if (mode_reg == uwt_pkg::SPLIT_WHITESPACE) return 1'b0;
        if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic code_is_delim(input logic [31:0] c);
        if (c == uwt_pkg::CP_NEL || c == uwt_pkg::CP_IDEO_SPACE || c == uwt_pkg::CP_BOM)
            return 1'b1;
        if (mode_reg == uwt_pkg::SPLIT_WORD)
            return c >= uwt_pkg::CP_PUNCT_LO && c <= uwt_pkg::CP_PUNCT_HI;
        return (c >= uwt_pkg::CP_PUNCT_LO && c <= uwt_pkg::CP_SPACE_HI)
            || (c >= uwt_pkg::CP_LINE_SEP && c <= uwt_pkg::CP_PARA_SEP)
            || c == uwt_pkg::CP_NARROW_NBSP
            || (c >= uwt_pkg::CP_MATH_SPACE && c <= uwt_pkg::CP_WORD_JOINER);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
        logic [16:0]   here;
        logic          char_done;
        logic          is_delim;
        logic          emit;
        int            lead_len;
        uwt_pkg::out_t tok;
        here = text_pos;
        char_done = 1'b0;
        is_delim = 1'b0;
        emit = 1'b0;
        tok = '0;
        if (cont_left != 3'd0) begin
            code_acc = {code_acc[25:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0 || eot) begin
                char_done = 1'b1;
                is_delim = code_is_delim(code_acc);
            end
        end else begin
            char_offset = (here < {1'b0, uwt_pkg::MAX_OFFSET}) ? here[15:0]
                                                               : uwt_pkg::MAX_OFFSET;
            if (b < 8'h80) begin
                char_done = 1'b1;
                is_delim = ascii_is_delim(b);
            end else if (b < 8'hC0 || b >= 8'hFE) begin
                char_done = 1'b1;
            end else begin
                if (b < 8'hE0) lead_len = 2;
                else if (b < 8'hF0) lead_len = 3;
                else if (b < 8'hF8) lead_len = 4;
                else if (b < 8'hFC) lead_len = 5;
                else lead_len = 6;
                code_acc = {24'd0, b & (8'h1F >> (lead_len - 2))};
                cont_left = 3'(lead_len - 1);
                if (eot) begin
                    char_done = 1'b1;
                    is_delim = code_is_delim(code_acc);
                end
            end
        end
        text_pos = (here < uwt_pkg::MAX_TEXT_BYTES) ? here + 17'd1 : uwt_pkg::MAX_TEXT_BYTES;
        if (char_done) begin
            if (is_delim) begin
                if (token_open) begin
                    tok.token_valid = 1'b1;
                    tok.token_start = token_origin;
                    tok.token_length = {1'b0, char_offset} - {1'b0, token_origin};
                    tok.text_done = eot;
                    token_open = 1'b0;
                    emit = 1'b1;
                end
            end else if (!token_open) begin
                token_open = 1'b1;
                token_origin = char_offset;
            end
        end
        if (eot) begin
            if (!emit) begin
                tok = '0;
                tok.text_done = 1'b1;
                if (token_open) begin
                    tok.token_valid = 1'b1;
                    tok.token_start = token_origin;
                    tok.token_length = text_pos - {1'b0, token_origin};
                end
                emit = 1'b1;
            end
            text_pos = '0;
            char_offset = '0;
            code_acc = '0;
            cont_left = '0;
            token_open = 1'b0;
            token_origin = '0;
        end
        if (emit) token_queue.insert(token_queue.size(), tok);
    endfunction

    always @(posedge aclk) begin : check_results
        uwt_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_queue.size() == 0) begin
                $display("%0t: unexpected result valid=%0d start=%0d length=%0d done=%0d",
                         $time, m_data.token_valid, m_data.token_start,
                         m_data.token_length, m_data.text_done);
                error_count++;
            end else begin
                want = token_queue.pop_front();
                if (m_data !== want) begin
                    $display("%0t: mismatch expected valid=%0d start=%0d length=%0d done=%0d",
                             $time, want.token_valid, want.token_start,
                             want.token_length, want.text_done);
                    $display("%0t:          actual   valid=%0d start=%0d length=%0d done=%0d",
                             $time, m_data.token_valid, m_data.token_start,
                             m_data.token_length, m_data.text_done);
                    error_count++;
                end
            end
        end
    end

    // sink: ready bursts broken by stalls, mostly short
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 120)) @(posedge aclk);
            else repeat ($urandom_range(1, 20)) @(posedge aclk);
            m_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge aclk);
            else repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    end

    function automatic int source_gap();
        int r;
        if (fast_source) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {b, eot};
        do @(posedge aclk); while (!s_ready);
        tokenize_byte(b, eot);
        items_sent++;
    endtask

    task automatic send_buffer();
        foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (token_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_split_mode(input logic m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_reg = m;
    endtask

    function automatic void put_code(input logic [31:0] code, input int n);
        logic [31:0] lead;
        lead = code >> (6 * (n - 1));
        buf_add((8'hFF << (8 - n)) | lead[7:0]);
        for (int k = n - 2; k >= 0; k--) buf_add({2'b10, 6'(code >> (6 * k))});
    endfunction

    function automatic void add_char();
        logic [31:0] near_edges[15] = '{32'd132, 32'd134, 32'h1FFF, 32'h2010, 32'h2027,
            32'h202A, 32'h202E, 32'h2030, 32'h205E, 32'h2061, 32'h2070, 32'h2FFF,
            32'h3001, 32'hFEFE, 32'hFF00};
        int          kind;
        int          n;
        int          r;
        logic [31:0] code;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            r = $urandom_range(0, 61);
            if (r < 10) buf_add(8'("0" + r));
            else if (r < 36) buf_add(8'("A" + r - 10));
            else buf_add(8'("a" + r - 36));
        end else if (kind < 52) begin
            buf_add(8'($urandom_range(0, 32)));
        end else if (kind < 62) begin
            buf_add(8'($urandom_range(33, 127)));
        end else if (kind < 74) begin
            r = $urandom_range(0, 7);
            case (r)
                0: code = uwt_pkg::CP_NEL;
                1: code = uwt_pkg::CP_IDEO_SPACE;
                2: code = uwt_pkg::CP_BOM;
                3: code = near_edges[$urandom_range(0, 14)];
                default: code = uwt_pkg::CP_PUNCT_LO + $urandom_range(0, 32'h6F);
            endcase
            n = (code < 32'h800) ? 2 : 3;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 6);
            put_code(code, n);
        end else if (kind < 90) begin
            n = $urandom_range(2, 6);
            code = $urandom & ((32'd1 << (5 * n + 1)) - 32'd1);
            put_code(code, n);
        end else if (kind < 95) begin
            buf_add(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
            buf_add(8'($urandom_range(8'hFE, 8'hFF)));
        end
    endfunction

    task automatic send_text(input int min_bytes, input bit cut_short);
        int drop;
        text_buf.delete();
        while (text_buf.size() < min_bytes) add_char();
        if (cut_short) begin
            drop = $urandom_range(1, 4);
            while (drop > 0 && text_buf.size() > 1) begin
                void'(text_buf.pop_back());
                drop--;
            end
        end
        send_buffer();
    endtask

    // reset mode is word mode; no register write before this test
    task automatic test_word_mode_directed();
        text_buf = '{"A", "z", "0", "9", " ", 8'h80, 8'hFE, "!", 8'hC2, 8'h85,
                     "x", 8'hE2, 8'h80, 8'h8B, 8'h7F, 8'h00, "q", 8'hF0, 8'h82, 8'h85};
        send_buffer();
        text_buf = '{8'hFF};
        send_buffer();
        text_buf = '{8'h20};
        send_buffer();
        drain();
    endtask

    task automatic test_whitespace_mode_directed();
        write_split_mode(uwt_pkg::SPLIT_WHITESPACE);
        text_buf = '{"-", 8'hE3, 8'h80, 8'h80, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                     8'hFC, 8'h20};
        send_buffer();
        drain();
    endtask

    task automatic test_random_texts();
        int  start_items;
        int  phase_items;
        logic m;
        start_items = items_sent;
        phase_items = items_sent;
        m = uwt_pkg::SPLIT_WORD;
        drain();
        write_split_mode(m);
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (items_sent - phase_items >= MODE_PHASE_ITEMS) begin
                drain();
                m = ~m;
                write_split_mode(m);
                phase_items = items_sent;
            end
            fast_source = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 12) begin
                text_buf.delete();
                repeat ($urandom_range(1, 40)) buf_add(8'($urandom_range(0, 255)));
                send_buffer();
            end else begin
                send_text($urandom_range(1, 40), $urandom_range(0, 99) < 15);
            end
        end
        fast_source = 1'b0;
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_word_mode_directed();
        test_whitespace_mode_directed();
        test_random_texts();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== utf8_word_tokenizer.f =====
+incdir+design
design/uwt_pkg.sv
design/utf8_word_tokenizer.sv
design/uwt_checker.sv
verif/utf8_word_tokenizer_tb.sv
